// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers used by the one RTL file that checks itself.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ck, rn, a, c) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
        else $error("check failed");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ck, rn, a, c) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) \
        else $error("check failed");

`endif

// File: src/pndn_pkg.sv
// ----------------------------------------------------------------------------
// pndn_pkg
// Types and constants shared by the packed normal decoder and normalizer.
// ----------------------------------------------------------------------------
`default_nettype none
package pndn_pkg;

    localparam int unsigned QBits    = 16;
    localparam int unsigned AccBits  = 64;
    localparam int unsigned NumSteps = 16;
    localparam logic [15:0] Q15Max   = 16'h7FFF;
    localparam logic [15:0] Q15One   = 16'h8000;

    typedef struct packed {
        logic [2:0]        neg;
        logic [2:0][10:0]  mag;
        logic [21:0]       sq_len;
    } front_item_t;

    typedef struct packed {
        logic signed [AccBits-1:0] res;
        logic signed [AccBits-1:0] acc;
        logic [QBits-1:0]          q;
    } lane_t;

    typedef struct packed {
        logic              valid;
        logic [2:0]        neg;
        logic [21:0]       sq_len;
        lane_t [2:0]       lane;
    } stage_t;

endpackage
`default_nettype wire

// File: src/pndn_front.sv
// ----------------------------------------------------------------------------
// pndn_front
// Splits a packed word into fields and forms magnitudes and squared length.
// ----------------------------------------------------------------------------
`default_nettype none
module pndn_front (
    input  wire logic [31:0]           packed_normal,
    output pndn_pkg::front_item_t      item
);

    // The common scale of 32 cancels, so z is carried at twice its field.
    logic signed [11:0] comp [3];
    logic [10:0]        mag  [3];
    logic [20:0]        sq   [3];

    always_comb
    begin
        comp[0] = 12'(signed'(packed_normal[10:0]));
        comp[1] = 12'(signed'(packed_normal[21:11]));
        comp[2] = 12'(signed'({packed_normal[31:22], 1'b0}));
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = comp[i][11] ? 11'(-comp[i]) : 11'(comp[i]);
            sq[i]  = 21'(mag[i]) * 21'(mag[i]);
            item.neg[i] = comp[i][11];
            item.mag[i] = mag[i];
        end
        item.sq_len = 22'(sq[0]) + 22'(sq[1]) + 22'(sq[2]);
    end

endmodule
`default_nettype wire

// File: src/pndn_fifo.sv
// ----------------------------------------------------------------------------
// pndn_fifo
// Short queue between the decode front and the normalizing back end.
// ----------------------------------------------------------------------------
`default_nettype none
module pndn_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   wr_en,
    input  wire pndn_pkg::front_item_t  wr_data,
    output logic                        full,
    input  wire logic                   rd_en,
    output pndn_pkg::front_item_t       rd_data,
    output logic                        not_empty
);

    localparam int unsigned PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntBits = $clog2(DEPTH + 1);

    pndn_pkg::front_item_t mem [DEPTH];
    logic [PtrBits-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CntBits-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == PtrBits'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == PtrBits'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (wr_en && !rd_en)
            count_next = count_reg + 1'b1;
        else if (rd_en && !wr_en)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= wr_data;
    end

    assign rd_data   = mem[rd_ptr_reg];
    assign full      = (count_reg == CntBits'(DEPTH));
    assign not_empty = (count_reg != '0);

endmodule
`default_nettype wire

// File: src/pndn_back.sv
// ----------------------------------------------------------------------------
// pndn_back
// Pipelined bit-by-bit rounding search per component and result register.
// ----------------------------------------------------------------------------
`default_nettype none
module pndn_back (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire pndn_pkg::front_item_t  in_item,
    output logic                        in_take,
    input  wire logic                   pop,
    output logic                        empty,
    output logic signed [15:0]          norm_x,
    output logic signed [15:0]          norm_y,
    output logic signed [15:0]          norm_z,
    output logic                        was_zero
);

    localparam int unsigned N = pndn_pkg::NumSteps;
    localparam int unsigned W = pndn_pkg::AccBits;

    pndn_pkg::stage_t stage_reg [N+1];
    pndn_pkg::stage_t stage_next [N+1];
    logic             out_valid_reg;
    logic [15:0]      res_reg [3];
    logic [15:0]      res_next [3];
    logic             zero_reg;
    logic             adv;

    assign adv     = !out_valid_reg || pop;
    assign in_take = adv && in_valid;

    // Search start: residual is m^2 * 2^32 - S for q = 0, accumulator -S.
    always_comb
    begin
        stage_next[0].valid  = in_valid;
        stage_next[0].neg    = in_item.neg;
        stage_next[0].sq_len = in_item.sq_len;
        for (int i = 0; i < 3; i++)
        begin
            stage_next[0].lane[i].res = (W'(22'(in_item.mag[i]) * 22'(in_item.mag[i])) << 32)
                - W'(in_item.sq_len);
            stage_next[0].lane[i].acc = -W'(in_item.sq_len);
            stage_next[0].lane[i].q   = '0;
        end
    end

    for (genvar s = 1; s <= N; s++)
    begin : g_step
        localparam int unsigned K = N - s;
        always_comb
        begin
            logic signed [W-1:0] trial;
            logic signed [W-1:0] sl;
            stage_next[s] = stage_reg[s-1];
            sl = W'(stage_reg[s-1].sq_len);
            for (int i = 0; i < 3; i++)
            begin
                trial = stage_reg[s-1].lane[i].res
                    - ((stage_reg[s-1].lane[i].acc <<< (K + 2)) + (sl <<< (2 * K + 2)));
                if (!trial[W-1])
                begin
                    stage_next[s].lane[i].res = trial;
                    stage_next[s].lane[i].acc = stage_reg[s-1].lane[i].acc + (sl <<< (K + 1));
                    stage_next[s].lane[i].q   = stage_reg[s-1].lane[i].q | (16'd1 << K);
                end
            end
        end
    end

    for (genvar s = 0; s <= N; s++)
    begin : g_reg
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                stage_reg[s] <= '0;
            else if (adv)
                stage_reg[s] <= stage_next[s];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (stage_reg[N].neg[i])
                res_next[i] = 16'(-stage_reg[N].lane[i].q);
            else if (stage_reg[N].lane[i].q == pndn_pkg::Q15One)
                res_next[i] = pndn_pkg::Q15Max;
            else
                res_next[i] = stage_reg[N].lane[i].q;
        end
        if (stage_reg[N].sq_len == '0)
        begin
            res_next[0] = '0;
            res_next[1] = pndn_pkg::Q15Max;
            res_next[2] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= stage_reg[N].valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg[0] <= res_next[0];
            res_reg[1] <= res_next[1];
            res_reg[2] <= res_next[2];
            zero_reg   <= (stage_reg[N].sq_len == '0);
        end
    end

    assign empty    = !out_valid_reg;
    assign norm_x   = res_reg[0];
    assign norm_y   = res_reg[1];
    assign norm_z   = res_reg[2];
    assign was_zero = zero_reg;

endmodule
`default_nettype wire

// File: src/packed_normal_decode_normalize_unit.sv
// ----------------------------------------------------------------------------
// packed_normal_decode_normalize_unit
// Decodes 11:11:10 packed normals into rounded Q1.15 unit vectors.
// ----------------------------------------------------------------------------
// Usage:
// Input items are written like a queue: an item is taken when push is high
// and full is low. Results are read like a queue: while empty is low the
// oldest result is on norm_x, norm_y, norm_z and was_zero, and pop takes it.
// Each item gives exactly one result, in order.
// An accepted item goes from the queue to the start stage, then through
// sixteen search stages (one result bit each, three components side by
// side) and into the result register.
// Throughput is one item per cycle while the reader keeps popping, set by
// the one-bit-per-stage pipeline.
// When the reader stops popping, the pipeline holds, the input queue of
// QUEUE_DEPTH items fills and full rises; nothing is lost.
// Reset empties the queue and the pipeline; there is no other state.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module packed_normal_decode_normalize_unit #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire logic [31:0]         packed_normal,
    output logic                     empty,
    input  wire logic                pop,
    output logic signed [15:0]       norm_x,
    output logic signed [15:0]       norm_y,
    output logic signed [15:0]       norm_z,
    output logic                     was_zero
);

    pndn_pkg::front_item_t front_item;
    pndn_pkg::front_item_t queue_item;
    logic                  queue_valid;
    logic                  queue_take;
    logic                  wr_en;
    logic                  zero_out_ok;

    assign wr_en = push && !full;
    assign zero_out_ok = (norm_x == 16'sd0) && (norm_y == 16'sd32767) && (norm_z == 16'sd0);

    pndn_front u_front (
        .packed_normal (packed_normal),
        .item          (front_item)
    );

    pndn_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_data   (front_item),
        .full      (full),
        .rd_en     (queue_take),
        .rd_data   (queue_item),
        .not_empty (queue_valid)
    );

    pndn_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (queue_valid),
        .in_item  (queue_item),
        .in_take  (queue_take),
        .pop      (pop),
        .empty    (empty),
        .norm_x   (norm_x),
        .norm_y   (norm_y),
        .norm_z   (norm_z),
        .was_zero (was_zero)
    );

    `ASSERT_SAME(a_zero_default, clk, rst_n, !empty && was_zero, zero_out_ok)
    `ASSERT_SAME(a_take_needs_item, clk, rst_n, queue_take, queue_valid)
    `ASSERT_NEXT(a_push_fills, clk, rst_n, wr_en && !queue_take, queue_valid)

endmodule
`default_nettype wire

// File: sim/tb_packed_normal_decode_normalize_unit.sv
// ----------------------------------------------------------------------------
// tb_packed_normal_decode_normalize_unit
// Checks the packed normal decoder against a bit-exact predictor that
// finds each rounded Q1.15 component by an exact integer search, with
// random gaps on the push side and random stalls on the pop side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class normal_scoreboard;
    logic [48:0] pending[$];
    int          mismatches;
    int          checked;

    function automatic logic [15:0] round_component(longint signed c, longint unsigned sq);
        logic [127:0] rhs;
        logic [127:0] lhs;
        longint unsigned m;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        logic [15:0] q;
        m = (c < 0) ? longint'(-c) : longint'(c);
        rhs = {64'd0, m * m} << 32;
        lo = 0;
        hi = 32768;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) >> 1;
            lhs = 128'(2 * mid - 1) * 128'(2 * mid - 1) * 128'(sq);
            if (lhs <= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        if (c < 0)
            q = 16'(0 - lo);
        else if (lo > 32767)
            q = 16'h7FFF;
        else
            q = 16'(lo);
        return q;
    endfunction

    function void note_normal(logic [31:0] w);
        longint signed x;
        longint signed y;
        longint signed z;
        longint unsigned sq;
        x = longint'($signed(w[10:0])) * 32;
        y = longint'($signed(w[21:11])) * 32;
        z = longint'($signed(w[31:22])) * 64;
        sq = x * x + y * y + z * z;
        if (sq == 0)
            pending.push_back({16'd0, 16'h7FFF, 16'd0, 1'b1});
        else
            pending.push_back({round_component(x, sq), round_component(y, sq),
                               round_component(z, sq), 1'b0});
    endfunction

    function void check_normal(logic [15:0] nx, logic [15:0] ny, logic [15:0] nz,
                               logic wz);
        logic [48:0] exp_v;
        checked++;
        if (pending.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected item x=%0d y=%0d z=%0d zero=%0b",
                         $signed(nx), $signed(ny), $signed(nz), wz);
            return;
        end
        exp_v = pending.pop_front();
        if (exp_v !== {nx, ny, nz, wz})
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("expected x=%0d y=%0d z=%0d zero=%0b, got x=%0d y=%0d z=%0d zero=%0b",
                         $signed(exp_v[48:33]), $signed(exp_v[32:17]), $signed(exp_v[16:1]),
                         exp_v[0], $signed(nx), $signed(ny), $signed(nz), wz);
        end
    endfunction
endclass

module tb_packed_normal_decode_normalize_unit;
    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [31:0] packed_normal;
    logic        empty;
    logic        pop;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic        was_zero;

    normal_scoreboard sb;
    int  cycles;
    int  sent;

    packed_normal_decode_normalize_unit dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .packed_normal(packed_normal), .empty(empty), .pop(pop),
        .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z), .was_zero(was_zero)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic push_normal(logic [31:0] w);
        int g;
        g = gap_length();
        if (g > 0)
        begin
            push <= 1'b0;
            repeat (g) @(posedge clk);
        end
        push <= 1'b1;
        packed_normal <= w;
        do
            @(posedge clk);
        while (full);
        sb.note_normal(w);
        sent++;
    endtask

    function automatic logic [31:0] pack_fields(int x, int y, int z);
        return {10'(z), 11'(y), 11'(x)};
    endfunction

    function automatic logic [31:0] random_normal();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return $urandom();
        else if (r < 7)
            return pack_fields($urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4,
                               $urandom_range(0, 8) - 4);
        else if (r < 8)
            return pack_fields(0, 0, $urandom_range(0, 1023));
        else if (r < 9)
            return pack_fields($urandom_range(0, 2047), 0, 0);
        return pack_fields(0, $urandom_range(0, 2047), 0);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            sb.check_normal(norm_x, norm_y, norm_z, was_zero);
    end

    initial
    begin
        int stall;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall > 0)
            begin
                stall--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
                if ($urandom_range(0, 9) == 0)
                    stall = gap_length();
            end
        end
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 400000)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("packed_normal_decode_normalize_unit: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        int w;
        sb = new();
        rst_n = 1'b0;
        push = 1'b0;
        packed_normal = 32'd0;
        sent = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        push_normal(32'd0);
        push_normal(32'hFFFF_FFFF);
        push_normal(pack_fields(1023, 0, 0));
        push_normal(pack_fields(-1024, 0, 0));
        push_normal(pack_fields(0, 1023, 0));
        push_normal(pack_fields(0, -1024, 0));
        push_normal(pack_fields(0, 0, 511));
        push_normal(pack_fields(0, 0, -512));
        push_normal(pack_fields(1023, 1023, 511));
        push_normal(pack_fields(-1024, -1024, -512));
        push_normal(pack_fields(1, 1, 0));
        push_normal(pack_fields(-1, 1, 1));
        push_normal(pack_fields(2, 0, -1));
        push_normal(pack_fields(1, 0, 0));
        push_normal(32'hAAAA_AAAA);
        push_normal(32'h5555_5555);
        for (w = 0; w < 750; w++)
            push_normal(random_normal());
        push <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        $display("Pushed %0d packed normals, checked %0d results, including zero,",
                 sent, sb.checked);
        $display("single-axis, extreme and random words under random stalls.");
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("packed_normal_decode_normalize_unit: match");
        else
            $display("packed_normal_decode_normalize_unit: mismatch");
        $finish;
    end
endmodule
